// File: sv/sequence_checked_watchdog_feed_top_assert.svh
// ----------------------------------------------------------------------------
// Watchdog feed gate assertion macros
// Shared property wrappers, all clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_CHECKED_WATCHDOG_FEED_TOP_ASSERT_SVH
`define SEQUENCE_CHECKED_WATCHDOG_FEED_TOP_ASSERT_SVH

// Same-cycle implication.
`define SCWF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SCWF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/scwf_pkg.sv
// ----------------------------------------------------------------------------
// Watchdog feed gate package
// Action codes, status codes, register indexes and result field layout.
// ----------------------------------------------------------------------------
package scwf_pkg;

   // Default checkpoint list width
   localparam int CHECKPOINT_BITS_DEF = 8;

   // Field widths
   localparam int ACTION_W   = 4;
   localparam int CP_FIELD_W = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 32;
   localparam int TIMER_W    = 17;
   localparam int MS_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_FIELDS_W = 2 + STATUS_W + 2 * CP_FIELD_W + 4 * COUNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Result field positions in rsp_tdata
   localparam int RSP_OP_LSB      = 0;
   localparam int RSP_PULSE_LSB   = 1;
   localparam int RSP_SST_LSB     = 2;
   localparam int RSP_NOW_LSB     = RSP_SST_LSB + STATUS_W;
   localparam int RSP_PREV_LSB    = RSP_NOW_LSB + CP_FIELD_W;
   localparam int RSP_FEEDS_LSB   = RSP_PREV_LSB + CP_FIELD_W;
   localparam int RSP_COMPL_LSB   = RSP_FEEDS_LSB + COUNT_W;
   localparam int RSP_TMO_LSB     = RSP_COMPL_LSB + COUNT_W;
   localparam int RSP_DENY_LSB    = RSP_TMO_LSB + COUNT_W;
   localparam int RSP_RUN_LSB     = RSP_DENY_LSB + COUNT_W;

   // Reset values of the configuration registers
   localparam logic [MS_W-1:0] FEED_INTERVAL_RST = 16'd500;
   localparam logic [MS_W-1:0] SEQ_TIMEOUT_RST   = 16'd5000;

   // Saturation limit of the millisecond timers
   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

   // Action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK        = 4'd0,
      ACT_SET         = 4'd1,
      ACT_CLEAR       = 4'd2,
      ACT_CHECKED     = 4'd3,
      ACT_PLAIN       = 4'd4,
      ACT_START       = 4'd5,
      ACT_STOP        = 4'd6,
      ACT_SEQ_RESET   = 4'd7,
      ACT_CHECK       = 4'd8,
      ACT_CLEAR_COUNT = 4'd9
   } action_type;

   // Sequence status codes
   typedef enum logic [STATUS_W-1:0] {
      SEQ_OK         = 3'd0,
      SEQ_INCOMPLETE = 3'd1,
      SEQ_TIMEOUT    = 3'd2,
      SEQ_DISABLED   = 3'd3,
      SEQ_NONE       = 3'd4
   } seq_status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FEED_INTERVAL = 3'd0,
      REG_SEQ_TIMEOUT   = 3'd1,
      REG_CRIT_MASK     = 3'd2,
      REG_AUTO_FEED     = 3'd3,
      REG_MONITOR       = 3'd4
   } reg_index_type;

endpackage

// File: sv/sequence_checked_watchdog_feed_top.sv
// ----------------------------------------------------------------------------
// Sequence-checked watchdog feed gate
// Gates watchdog refreshes on a checkpoint bitmask, with millisecond timers,
// automatic feeding and wrapping event counters.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_tvalid/tready    action, checkpoint_mask
//   rsp_      out        rsp_tvalid/tready    status, checklists, counters
//   csr_      in         csr_valid/ready      register index, write data
//
// One item is taken per cycle while req_tready is high; its result appears in
// the result register on the cycle after the transfer.
// All per-item work is one pass of compare and counter logic from the state
// registers into the result register, which is the only stage.
// The input side stalls only while a result waits and rsp_tready is low, and
// while a configuration write is presented; csr_ready is always high.
// Reset is synchronous and restores every state and configuration register.
// ----------------------------------------------------------------------------
module sequence_checked_watchdog_feed_top #(
   parameter int CHECKPOINT_BITS = scwf_pkg::CHECKPOINT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // [3:0] action, [11:4] checkpoint_mask, [15:12] zero
   input  logic [scwf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] op_status, [1] feed_pulse, [4:2] seq_status, [12:5] checklist_now,
   // [20:13] checklist_prev, [52:21] feeds_done, [84:53] completes_seen,
   // [116:85] timeouts_seen, [148:117] denials_seen, [149] is_running,
   // [151:150] zero
   output logic [scwf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [scwf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scwf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Width of the checklist actually stored
   localparam int CL_W = (CHECKPOINT_BITS < scwf_pkg::CP_FIELD_W) ?
                         CHECKPOINT_BITS : scwf_pkg::CP_FIELD_W;
   localparam int PAD_W = scwf_pkg::RSP_DATA_W - scwf_pkg::RSP_FIELDS_W;

   // Configuration registers
   logic [scwf_pkg::MS_W-1:0]    feed_interval_ff, feed_interval_in;
   logic [scwf_pkg::MS_W-1:0]    seq_timeout_ff, seq_timeout_in;
   logic [CL_W-1:0]              crit_mask_ff, crit_mask_in;
   logic                         auto_en_ff, auto_en_in;
   logic                         mon_en_ff, mon_en_in;

   // Monitor state
   logic                         running_ff, running_in;
   logic                         revoked_ff, revoked_in;
   logic [CL_W-1:0]              checklist_ff, checklist_in;
   logic [CL_W-1:0]              prev_list_ff, prev_list_in;
   logic [scwf_pkg::TIMER_W-1:0] seq_elapsed_ff, seq_elapsed_in;
   logic [scwf_pkg::TIMER_W-1:0] feed_elapsed_ff, feed_elapsed_in;
   logic [scwf_pkg::COUNT_W-1:0] feed_cnt_ff, feed_cnt_in;
   logic [scwf_pkg::COUNT_W-1:0] compl_cnt_ff, compl_cnt_in;
   logic [scwf_pkg::COUNT_W-1:0] tmo_cnt_ff, tmo_cnt_in;
   logic [scwf_pkg::COUNT_W-1:0] deny_cnt_ff, deny_cnt_in;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [scwf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Per-item working signals
   logic                         req_xfer;
   logic                         csr_xfer;
   scwf_pkg::action_type         req_action;
   logic [CL_W-1:0]              req_cp_mask;
   scwf_pkg::seq_status_type     eval_st;
   scwf_pkg::seq_status_type     sst;
   logic                         op_st;
   logic                         pulse;
   logic [scwf_pkg::TIMER_W-1:0] seq_tick;
   logic [scwf_pkg::TIMER_W-1:0] feed_tick;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid;
   assign req_tready = (!rsp_valid_ff || rsp_tready) && !csr_valid;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Input field extraction
   assign req_action  = scwf_pkg::action_type'(req_tdata[scwf_pkg::ACTION_W-1:0]);
   assign req_cp_mask = req_tdata[scwf_pkg::ACTION_W +: CL_W];

   // Saturating timer increments for a tick
   assign seq_tick  = (seq_elapsed_ff < scwf_pkg::TIMER_MAX) ?
                      seq_elapsed_ff + 1'b1 : seq_elapsed_ff;
   assign feed_tick = (feed_elapsed_ff < scwf_pkg::TIMER_MAX) ?
                      feed_elapsed_ff + 1'b1 : feed_elapsed_ff;

   // Sequence evaluation shared by checked feed and check
   always_comb begin
      priority if (!mon_en_ff) begin
         eval_st = scwf_pkg::SEQ_DISABLED;
      end else if (seq_elapsed_ff > {1'b0, seq_timeout_ff}) begin
         eval_st = scwf_pkg::SEQ_TIMEOUT;
      end else if ((checklist_ff & crit_mask_ff) == crit_mask_ff) begin
         eval_st = scwf_pkg::SEQ_OK;
      end else begin
         eval_st = scwf_pkg::SEQ_INCOMPLETE;
      end
   end

   // Next state: a configuration write, else an accepted item
   always_comb begin
      feed_interval_in = feed_interval_ff;
      seq_timeout_in   = seq_timeout_ff;
      crit_mask_in     = crit_mask_ff;
      auto_en_in       = auto_en_ff;
      mon_en_in        = mon_en_ff;
      running_in       = running_ff;
      revoked_in       = revoked_ff;
      checklist_in     = checklist_ff;
      prev_list_in     = prev_list_ff;
      seq_elapsed_in   = seq_elapsed_ff;
      feed_elapsed_in  = feed_elapsed_ff;
      feed_cnt_in      = feed_cnt_ff;
      compl_cnt_in     = compl_cnt_ff;
      tmo_cnt_in       = tmo_cnt_ff;
      deny_cnt_in      = deny_cnt_ff;
      sst              = scwf_pkg::SEQ_NONE;
      op_st            = 1'b0;
      pulse            = 1'b0;

      if (csr_xfer) begin
         unique case (csr_index)
            scwf_pkg::REG_FEED_INTERVAL: begin
               feed_interval_in = csr_wdata;
            end
            scwf_pkg::REG_SEQ_TIMEOUT: begin
               seq_timeout_in = csr_wdata;
            end
            scwf_pkg::REG_CRIT_MASK: begin
               crit_mask_in = csr_wdata[CL_W-1:0];
            end
            scwf_pkg::REG_AUTO_FEED: begin
               auto_en_in = csr_wdata[0];
               revoked_in = 1'b0;
            end
            scwf_pkg::REG_MONITOR: begin
               mon_en_in = csr_wdata[0];
               if (csr_wdata[0]) begin
                  prev_list_in   = checklist_ff;
                  checklist_in   = '0;
                  seq_elapsed_in = '0;
               end
            end
            default: begin
            end
         endcase
      end else if (req_xfer) begin
         unique case (req_action)
            scwf_pkg::ACT_TICK: begin
               seq_elapsed_in  = seq_tick;
               feed_elapsed_in = feed_tick;
               if (running_ff && auto_en_ff && !revoked_ff &&
                   feed_tick >= {1'b0, feed_interval_ff}) begin
                  feed_cnt_in     = feed_cnt_ff + 1'b1;
                  feed_elapsed_in = '0;
                  pulse           = 1'b1;
               end
            end
            scwf_pkg::ACT_SET: begin
               if (mon_en_ff) begin
                  if (checklist_ff == '0) begin
                     seq_elapsed_in = '0;
                  end
                  checklist_in = checklist_ff | req_cp_mask;
               end
            end
            scwf_pkg::ACT_CLEAR: begin
               if (mon_en_ff) begin
                  checklist_in = checklist_ff & ~req_cp_mask;
               end
            end
            scwf_pkg::ACT_CHECKED: begin
               if (!running_ff) begin
                  op_st = 1'b1;
               end else begin
                  sst = eval_st;
                  if (eval_st == scwf_pkg::SEQ_INCOMPLETE) begin
                     deny_cnt_in = deny_cnt_ff + 1'b1;
                     op_st       = 1'b1;
                  end else begin
                     if (eval_st == scwf_pkg::SEQ_TIMEOUT) begin
                        tmo_cnt_in = tmo_cnt_ff + 1'b1;
                     end
                     if (eval_st == scwf_pkg::SEQ_OK) begin
                        compl_cnt_in = compl_cnt_ff + 1'b1;
                     end
                     if (eval_st != scwf_pkg::SEQ_DISABLED) begin
                        prev_list_in   = checklist_ff;
                        checklist_in   = '0;
                        seq_elapsed_in = '0;
                     end
                     feed_cnt_in     = feed_cnt_ff + 1'b1;
                     feed_elapsed_in = '0;
                     pulse           = 1'b1;
                  end
               end
            end
            scwf_pkg::ACT_PLAIN: begin
               if (running_ff) begin
                  feed_cnt_in     = feed_cnt_ff + 1'b1;
                  feed_elapsed_in = '0;
                  pulse           = 1'b1;
               end else begin
                  op_st = 1'b1;
               end
            end
            scwf_pkg::ACT_START: begin
               running_in      = 1'b1;
               feed_elapsed_in = '0;
               feed_cnt_in     = '0;
            end
            scwf_pkg::ACT_STOP: begin
               running_in = 1'b0;
               revoked_in = 1'b1;
            end
            scwf_pkg::ACT_SEQ_RESET: begin
               prev_list_in   = checklist_ff;
               checklist_in   = '0;
               seq_elapsed_in = '0;
            end
            scwf_pkg::ACT_CHECK: begin
               sst = eval_st;
               if (eval_st == scwf_pkg::SEQ_TIMEOUT) begin
                  tmo_cnt_in = tmo_cnt_ff + 1'b1;
               end
               if (eval_st == scwf_pkg::SEQ_OK) begin
                  compl_cnt_in = compl_cnt_ff + 1'b1;
               end
            end
            scwf_pkg::ACT_CLEAR_COUNT: begin
               feed_cnt_in = '0;
            end
            default: begin
               op_st = 1'b1;
            end
         endcase
      end
   end

   // Result register: load on an input transfer, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, running_in, deny_cnt_in, tmo_cnt_in,
                         compl_cnt_in, feed_cnt_in,
                         scwf_pkg::CP_FIELD_W'(prev_list_in),
                         scwf_pkg::CP_FIELD_W'(checklist_in),
                         sst, pulse, op_st};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_interval_ff <= scwf_pkg::FEED_INTERVAL_RST;
         seq_timeout_ff   <= scwf_pkg::SEQ_TIMEOUT_RST;
         crit_mask_ff     <= '1;
         auto_en_ff       <= 1'b1;
         mon_en_ff        <= 1'b1;
         running_ff       <= 1'b0;
         revoked_ff       <= 1'b0;
         checklist_ff     <= '0;
         prev_list_ff     <= '0;
         seq_elapsed_ff   <= '0;
         feed_elapsed_ff  <= '0;
         feed_cnt_ff      <= '0;
         compl_cnt_ff     <= '0;
         tmo_cnt_ff       <= '0;
         deny_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         feed_interval_ff <= feed_interval_in;
         seq_timeout_ff   <= seq_timeout_in;
         crit_mask_ff     <= crit_mask_in;
         auto_en_ff       <= auto_en_in;
         mon_en_ff        <= mon_en_in;
         running_ff       <= running_in;
         revoked_ff       <= revoked_in;
         checklist_ff     <= checklist_in;
         prev_list_ff     <= prev_list_in;
         seq_elapsed_ff   <= seq_elapsed_in;
         feed_elapsed_ff  <= feed_elapsed_in;
         feed_cnt_ff      <= feed_cnt_in;
         compl_cnt_ff     <= compl_cnt_in;
         tmo_cnt_ff       <= tmo_cnt_in;
         deny_cnt_ff      <= deny_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
`include "sequence_checked_watchdog_feed_top_assert.svh"

   // A refresh is only ever reported while the watchdog runs.
   `SCWF_ASSERT_NOW(a_pulse_running,
      rsp_valid_ff && rsp_data_ff[scwf_pkg::RSP_PULSE_LSB],
      rsp_data_ff[scwf_pkg::RSP_RUN_LSB], "feed pulse while stopped")

   // A pending refresh result matches a freshly cleared since-feed timer.
   `SCWF_ASSERT_NOW(a_pulse_timer,
      rsp_valid_ff && rsp_data_ff[scwf_pkg::RSP_PULSE_LSB],
      feed_elapsed_ff == '0, "feed timer not cleared by refresh")

   // No item taken while stopped can refresh the watchdog.
   `SCWF_ASSERT_NEXT(a_stopped_nofeed, req_xfer && !running_ff,
      !rsp_data_ff[scwf_pkg::RSP_PULSE_LSB], "refresh from stopped state")

endmodule
